### rtl/gda_pkg.sv
// shared constants, types and calendar helpers for the date advance block
package gda_pkg;

    localparam int YEAR_BITS = 15;
    localparam int MODE_W    = 3;
    localparam int COUNT_W   = 15;
    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;

    // day count for week mode is count * 7
    localparam int N_W    = COUNT_W + 3;
    // count * 100 for century mode
    localparam int PROD_W = COUNT_W + 7;
    localparam int SUM_W  = ((YEAR_BITS > PROD_W) ? YEAR_BITS : PROD_W) + 1;
    // divider covers both the year and the month total (month index plus count)
    localparam int DIV_W  = (YEAR_BITS > COUNT_W + 1) ? YEAR_BITS : COUNT_W + 1;
    localparam int DIVR_W = 9;

    // reciprocals for 400 = 16 * 25 and 12 = 4 * 3, exact over the whole dividend range
    localparam int RECIP_W = DIV_W + 1;
    localparam logic [RECIP_W-1:0] RECIP_25 =
        RECIP_W'(((64'd1 << RECIP_W) + 64'd24) / 64'd25);
    localparam logic [RECIP_W-1:0] RECIP_3  =
        RECIP_W'(((64'd1 << RECIP_W) + 64'd2) / 64'd3);

    localparam logic [YEAR_BITS-1:0] YEAR_MAX      = '1;
    localparam logic [DIVR_W-1:0]    DIVISOR_CYCLE = DIVR_W'(400);
    localparam logic [DIVR_W-1:0]    DIVISOR_YEAR  = DIVR_W'(12);
    localparam logic [MONTH_W-1:0]   MONTH_JAN     = MONTH_W'(1);
    localparam logic [MONTH_W-1:0]   MONTH_DEC     = MONTH_W'(12);
    localparam logic [DAY_W-1:0]     DAY_FIRST     = DAY_W'(1);
    localparam logic [DAY_W-1:0]     DAY_LAST_DEC  = DAY_W'(31);
    localparam logic [DAY_W-1:0]     DAY_SAFE      = DAY_W'(28);
    localparam logic [2:0]           DAYS_PER_WEEK = 3'd7;
    localparam logic [6:0]           YEARS_DECADE  = 7'd10;
    localparam logic [6:0]           YEARS_CENTURY = 7'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_DAYS      = 3'd0,
        MODE_WEEKS     = 3'd1,
        MODE_MONTHS    = 3'd2,
        MODE_YEARS     = 3'd3,
        MODE_DECADES   = 3'd4,
        MODE_CENTURIES = 3'd5
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_CHECK,
        S_DAY,
        S_MCLAMP,
        S_MDIV,
        S_YMUL,
        S_YADD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_W-1:0]    dividend;
        logic [DIVR_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_W-1:0]    quo;
        logic [DIVR_W-1:0]   rem;
    } div_rsp_t;

    // leap from the low year bits and the year modulo 400
    function automatic logic is_leap(input logic [1:0] ylow, input logic [DIVR_W-1:0] r400);
        return (ylow == 2'd0) && (r400 != DIVR_W'(100)) && (r400 != DIVR_W'(200))
               && (r400 != DIVR_W'(300));
    endfunction

    function automatic logic [DIVR_W-1:0] r400_inc(input logic [DIVR_W-1:0] r400);
        return (r400 == DIVR_W'(399)) ? '0 : r400 + 1'b1;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/gregorian_date_advance.sv
// gregorian date advance: sequencer around a shared reciprocal divider
//
// one item in, one item out. the input channel (in_valid / in_stall) takes a
// mode, a count and a starting date; the output channel (out_valid / out_stall)
// returns the advanced date with the overflow and bad-date flags.
// the block handles one item at a time: in_stall is high from acceptance
// until the result has been taken.
// every item first splits the year by 400 in the divider for the leap rule and
// then passes a check state, from which a bad date or a spare mode code goes
// straight to the output.
// days and weeks: the date walks forward a month boundary at a time, then the
// remaining days are added to the day.
// months: single-month clamp steps while the day is above 28, then the
// month total is split by 12 in the divider.
// years, decades, centuries: a multiply state and then an add state.
// the result sits in registers with out_valid high for as long as out_stall
// holds it; the next item is taken the cycle after it leaves.
// reset returns the sequencer to idle and drops out_valid; no clearing pass.
module gregorian_date_advance
    import gda_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [COUNT_W-1:0]   count,
    input  logic [DAY_W-1:0]     day_in,
    input  logic [MONTH_W-1:0]   month_in,
    input  logic [YEAR_BITS-1:0] year_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DAY_W-1:0]     day_out,
    output logic [MONTH_W-1:0]   month_out,
    output logic [YEAR_BITS-1:0] year_out,
    output logic                 year_overflow,
    output logic                 bad_date
);

    state_t               state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [DAY_W-1:0]     d_reg, d_next;
    logic [MONTH_W-1:0]   m_reg, m_next;
    logic [YEAR_BITS-1:0] y_reg, y_next;
    logic [N_W-1:0]       n_reg, n_next;
    logic [DIVR_W-1:0]    r400_reg, r400_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 ovf_reg, ovf_next;
    logic                 bad_reg, bad_next;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [DAY_W-1:0]     dim_cur;
    logic [DAY_W-1:0]     left;
    logic                 at_max;
    logic                 wrap;
    logic [MONTH_W-1:0]   nm;
    logic [YEAR_BITS-1:0] ny;
    logic [DIVR_W-1:0]    nr;
    logic [DAY_W-1:0]     dim_new;
    logic [DIV_W-1:0]     total;
    logic [DIV_W:0]       q_sum;
    logic [SUM_W-1:0]     y_sum;
    logic [6:0]           mul_k;

    gda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        dim_cur = month_days(m_reg, is_leap(y_reg[1:0], r400_reg));
        left    = dim_cur - d_reg;
        at_max  = (y_reg == YEAR_MAX);
        wrap    = (m_reg == MONTH_DEC);
        // the month after the current one
        nm      = wrap ? MONTH_JAN : m_reg + 1'b1;
        ny      = wrap ? y_reg + 1'b1 : y_reg;
        nr      = wrap ? r400_inc(r400_reg) : r400_reg;
        dim_new = month_days(nm, is_leap(ny[1:0], nr));
        total   = DIV_W'(m_reg - 1'b1) + DIV_W'(n_reg[COUNT_W-1:0]);
        q_sum   = (DIV_W + 1)'(y_reg) + (DIV_W + 1)'(div_rsp.quo);
        y_sum   = SUM_W'(y_reg) + SUM_W'(prod_reg);

        case (mode_t'(mode_reg))
            MODE_DECADES:   mul_k = YEARS_DECADE;
            MODE_CENTURIES: mul_k = YEARS_CENTURY;
            default:        mul_k = 7'd1;
        endcase

        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        r400_next  = r400_reg;
        prod_next  = prod_reg;
        ovf_next   = ovf_reg;
        bad_next   = bad_reg;
        div_req    = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    mode_next        = mode;
                    cnt_next         = count;
                    d_next           = day_in;
                    m_next           = month_in;
                    y_next           = year_in;
                    ovf_next         = 1'b0;
                    bad_next         = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(year_in);
                    div_req.divisor  = DIVISOR_CYCLE;
                    state_next       = S_MOD;
                end
            end

            S_MOD:
            begin
                if (div_rsp.done)
                begin
                    r400_next  = div_rsp.rem;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if ((m_reg == '0) || (m_reg > MONTH_DEC) || (d_reg == '0) || (d_reg > dim_cur))
                begin
                    bad_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    case (mode_t'(mode_reg))
                        MODE_DAYS:
                        begin
                            n_next     = N_W'(cnt_reg);
                            state_next = S_DAY;
                        end
                        MODE_WEEKS:
                        begin
                            n_next     = N_W'(cnt_reg) * N_W'(DAYS_PER_WEEK);
                            state_next = S_DAY;
                        end
                        MODE_MONTHS:
                        begin
                            n_next     = N_W'(cnt_reg);
                            state_next = S_MCLAMP;
                        end
                        MODE_YEARS, MODE_DECADES, MODE_CENTURIES:
                        begin
                            state_next = S_YMUL;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            // one month boundary per cycle
            S_DAY:
            begin
                if (n_reg <= N_W'(left))
                begin
                    d_next     = d_reg + n_reg[DAY_W-1:0];
                    state_next = S_OUT;
                end
                else
                begin
                    n_next = n_reg - N_W'(left) - 1'b1;
                    d_next = DAY_FIRST;
                    if (wrap && at_max)
                    begin
                        ovf_next   = 1'b1;
                        d_next     = DAY_LAST_DEC;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        m_next    = nm;
                        y_next    = ny;
                        r400_next = nr;
                    end
                end
            end

            // single months while the day can still be clamped
            S_MCLAMP:
            begin
                if (n_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (d_reg <= DAY_SAFE)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = total;
                    div_req.divisor  = DIVISOR_YEAR;
                    state_next       = S_MDIV;
                end
                else if (wrap && at_max)
                begin
                    ovf_next   = 1'b1;
                    d_next     = DAY_LAST_DEC;
                    state_next = S_OUT;
                end
                else
                begin
                    m_next    = nm;
                    y_next    = ny;
                    r400_next = nr;
                    d_next    = (d_reg > dim_new) ? dim_new : d_reg;
                    n_next    = n_reg - 1'b1;
                end
            end

            S_MDIV:
            begin
                if (div_rsp.done)
                begin
                    if (q_sum > (DIV_W + 1)'(YEAR_MAX))
                    begin
                        ovf_next = 1'b1;
                        d_next   = DAY_LAST_DEC;
                        m_next   = MONTH_DEC;
                        y_next   = YEAR_MAX;
                    end
                    else
                    begin
                        y_next = q_sum[YEAR_BITS-1:0];
                        m_next = div_rsp.rem[MONTH_W-1:0] + 1'b1;
                    end
                    state_next = S_OUT;
                end
            end

            S_YMUL:
            begin
                prod_next  = PROD_W'(cnt_reg) * PROD_W'(mul_k);
                state_next = S_YADD;
            end

            S_YADD:
            begin
                if (y_sum > SUM_W'(YEAR_MAX))
                begin
                    ovf_next = 1'b1;
                    y_next   = YEAR_MAX;
                end
                else
                begin
                    y_next = y_sum[YEAR_BITS-1:0];
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        d_reg    <= d_next;
        m_reg    <= m_next;
        y_reg    <= y_next;
        n_reg    <= n_next;
        r400_reg <= r400_next;
        prod_reg <= prod_next;
        ovf_reg  <= ovf_next;
        bad_reg  <= bad_next;
    end

    assign day_out       = d_reg;
    assign month_out     = m_reg;
    assign year_out      = y_reg;
    assign year_overflow = ovf_reg;
    assign bad_date      = bad_reg;

    // an overflowed result always carries the saturated year
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && year_overflow |-> year_out == YEAR_MAX)
        else $error("overflow without saturated year");

    // the two flags never come together
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(year_overflow && bad_date))
        else $error("overflow and bad date both set");

    // a good date leaves with a month in 1..12 and a day of at least 1
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_date |-> month_out >= MONTH_JAN && month_out <= MONTH_DEC
                                   && day_out >= DAY_FIRST)
        else $error("result date out of range");

    // the divider answers only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_MOD || state_reg == S_MDIV)
        else $error("divider result with nobody waiting");

    // a new item never produces its result on the next edge
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid)
        else $error("result too early");

endmodule

### rtl/gda_div.sv
// divider by 400 or 12 on one shared multiplier: reciprocal quotient, then remainder
module gda_div
    import gda_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                     busy_reg, busy_next;
    logic                     phase_reg, phase_next;
    logic                     done_reg, done_next;
    logic                     cyc_reg, cyc_next;
    logic [DIV_W-1:0]         dvd_reg, dvd_next;
    logic [DIV_W-1:0]         quo_reg, quo_next;
    logic [DIVR_W-1:0]        rem_reg, rem_next;
    logic [DIVR_W-1:0]        dsr_reg, dsr_next;

    logic [DIV_W-1:0]         mul_a;
    logic [RECIP_W-1:0]       mul_b;
    logic [DIV_W+RECIP_W-1:0] prod;
    logic [DIV_W-1:0]         diff;

    always_comb
    begin
        // first pass: shifted dividend times reciprocal, second pass: quotient times divisor
        mul_a = cyc_reg ? (dvd_reg >> 4) : (dvd_reg >> 2);
        mul_b = cyc_reg ? RECIP_25 : RECIP_3;
        if (phase_reg)
        begin
            mul_a = quo_reg;
            mul_b = RECIP_W'(dsr_reg);
        end
        prod = (DIV_W + RECIP_W)'(mul_a) * (DIV_W + RECIP_W)'(mul_b);
        diff = dvd_reg - prod[DIV_W-1:0];

        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        cyc_next   = cyc_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cyc_next   = (req.divisor == DIVISOR_CYCLE);
            dvd_next   = req.dividend;
            dsr_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                quo_next   = prod[DIV_W+RECIP_W-1:RECIP_W];
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = diff[DIVR_W-1:0];
                phase_next = 1'b0;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cyc_reg <= cyc_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
